// ===== design/spectral_kalman_denoise_bin_macros.svh =====
// Assertion helpers used by the denoiser RTL.
`ifndef SPECTRAL_KALMAN_DENOISE_BIN_MACROS_SVH
`define SPECTRAL_KALMAN_DENOISE_BIN_MACROS_SVH

// Condition must hold on every rising clock edge out of reset.
`define SKD_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SKD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/skd_pkg.sv =====
`default_nettype none
package skd_pkg;

    localparam int BIN_W       = 12;
    localparam int RATIO_W     = 16;
    localparam int RATIO_FRAC  = 8;
    localparam int FRAC_W      = 16;
    localparam int GAIN_W      = 17;
    localparam int DIV_STEPS   = 16;
    localparam int MOD_SHIFT   = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int Q16_ONE     = 65536;
    localparam int ROUND_Q16   = 32768;
    localparam int VAR_RESET   = 1;
    localparam int RATIO_RESET = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE_VARIANCE = 2'd0,
        CFG_MOTION_RATIO   = 2'd1,
        CFG_USE_PATTERN    = 2'd2
    } cfg_reg_t;

endpackage
`default_nettype wire

// ===== design/spectral_kalman_denoise_bin.sv =====
// Per-bin scalar Kalman denoiser for complex coefficients. Each item carries a bin index,
// a complex coefficient and an optional per-bin noise variance; one filtered coefficient
// and a motion flag come back per item, in order. State for all bins lives in one
// single-port-write, registered-read memory and is updated by a read-modify-write
// pipeline: three input stages (variance select, motion threshold and bin reduction),
// the state read, sum and denominator, a sixteen-stage restoring divider and a rounding
// stage for the Q1.16 gain, and two multiply stages before writeback. With no stalls,
// items for distinct bins are taken one per cycle. An item whose bin is still in that
// pipeline waits at the read stage until the earlier item has written back. After reset
// the state memory is cleared one entry a cycle, all BINS entries, with s_tready low;
// configuration writes are taken at any time and must only be issued while the block is
// idle. A two-entry output buffer keeps the pipeline running while a result waits on
// m_tready; the pipeline stalls once both entries are full.
`default_nettype none
`include "spectral_kalman_denoise_bin_macros.svh"
module spectral_kalman_denoise_bin #(
    parameter int BINS      = 4096,
    parameter int COEF_BITS = 24,
    parameter int VAR_BITS  = 48
) (
    input  logic aclk,
    input  logic aresetn,
    // bin_index, cur_re, cur_im, bin_variance
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((skd_pkg::BIN_W + 2*COEF_BITS + VAR_BITS + 7)/8)*8-1:0] s_tdata,
    // out_bin, out_re, out_im
    output logic m_tvalid,
    input  logic m_tready,
    output logic [((skd_pkg::BIN_W + 2*COEF_BITS + 7)/8)*8-1:0] m_tdata,
    // motion
    output logic m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [skd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [VAR_BITS-1:0] cfg_data
);

    import skd_pkg::*;

    localparam int C       = COEF_BITS;
    localparam int V       = VAR_BITS;
    localparam int ADDR_W  = $clog2(BINS);
    localparam int OUT_W   = ((BIN_W + 2*COEF_BITS + 7)/8)*8;
    localparam int THR_W   = V + RATIO_W - RATIO_FRAC;
    localparam int SQ_W    = 2*C + 1;
    localparam int CMP_W   = (SQ_W > THR_W) ? SQ_W : THR_W;
    localparam int MP_W    = BIN_W + MOD_SHIFT + 1;
    localparam int AW      = C + GAIN_W + 2;
    localparam int RECIP   = (2**MOD_SHIFT + BINS - 1) / BINS;
    localparam int S_READ  = 0;
    localparam int S_SUM   = 1;
    localparam int S_DEN   = 2;
    localparam int S_DIV0  = 3;
    localparam int S_GAIN  = S_DIV0 + DIV_STEPS;
    localparam int S_MUL   = S_GAIN + 1;
    localparam int S_COVP  = S_MUL + 1;
    localparam int NST     = S_COVP + 1;

    typedef struct packed {
        logic [V-1:0]        covp_im;
        logic [V-1:0]        covp_re;
        logic [V-1:0]        cov_im;
        logic [V-1:0]        cov_re;
        logic signed [C-1:0] prev_im;
        logic signed [C-1:0] prev_re;
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [BIN_W-1:0]    bin;
        logic [BIN_W-1:0]    qm;
        logic signed [C-1:0] cur_re;
        logic signed [C-1:0] cur_im;
        logic signed [C-1:0] prev_re;
        logic signed [C-1:0] prev_im;
        logic signed [C-1:0] out_re;
        logic signed [C-1:0] out_im;
        logic [V-1:0]        sigma;
        logic [THR_W-1:0]    thr;
        logic signed [C:0]   d_re;
        logic signed [C:0]   d_im;
        logic [V-1:0]        sum_re;
        logic [V-1:0]        sum_im;
        logic [V:0]          den_re;
        logic [V:0]          den_im;
        logic [V:0]          r_re;
        logic [V:0]          r_im;
        logic [GAIN_W-1:0]   q_re;
        logic [GAIN_W-1:0]   q_im;
        logic [SQ_W-1:0]     sq_re;
        logic [SQ_W-1:0]     sq_im;
        logic [V-1:0]        t_re;
        logic [V-1:0]        t_im;
        logic [V-1:0]        cov_re;
        logic [V-1:0]        cov_im;
        logic [V-1:0]        covp_re;
        logic [V-1:0]        covp_im;
        logic                motion;
    } item_t;

    typedef struct packed {
        logic                motion;
        logic signed [C-1:0] im;
        logic signed [C-1:0] re;
        logic [BIN_W-1:0]    bin;
    } out_t;

    function automatic logic [V-1:0] sat_sum(input logic [V-1:0] a, input logic [V-1:0] b);
        logic [V:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[V] ? {V{1'b1}} : s[V-1:0];
    endfunction

    function automatic logic [V-1:0] mul_round(input logic [GAIN_W-1:0] g,
                                               input logic [V-1:0] x);
        logic [GAIN_W+V-1:0] p;
        p = (GAIN_W+V)'(g) * (GAIN_W+V)'(x) + (GAIN_W+V)'(ROUND_Q16);
        return p[FRAC_W +: V];
    endfunction

    function automatic logic signed [C-1:0] blend(input logic signed [C-1:0] prev,
                                                  input logic signed [C:0] d,
                                                  input logic [GAIN_W-1:0] g);
        logic signed [AW-1:0] acc;
        acc = (AW'(prev) <<< FRAC_W) + AW'($signed({1'b0, g})) * AW'(d)
            + AW'(ROUND_Q16);
        return acc[FRAC_W +: C];
    endfunction

    // configuration
    logic [V-1:0]       noise_var_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               use_pat_reg;

    // control
    logic              clr_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [2:0]        pre_v_reg;
    logic [NST-1:0]    st_v_reg;
    logic              m_v_reg, m_v_next;
    logic              skid_v_reg, skid_v_next;

    // payload
    item_t  pre_reg [3];
    item_t  pre_next [3];
    item_t  st_reg [NST];
    item_t  st_next [NST];
    out_t   main_reg, main_next, skid_reg, skid_next, push_item;
    state_t state_q, state_wb;

    logic run, conflict, dup_hit, pre_move, accept, rd_issue, push, pop;
    logic gain_ok;
    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [$bits(state_t)-1:0] ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;
    assign run       = !skid_v_reg;
    assign pre_move  = run && !conflict;
    assign s_tready  = !clr_reg && pre_move;
    assign accept    = s_tvalid && s_tready;
    assign rd_issue  = pre_move && pre_v_reg[2];
    assign push      = run && st_v_reg[S_COVP];
    assign pop       = m_v_reg && m_tready;

    always_comb begin
        conflict = 1'b0;
        dup_hit  = 1'b0;
        for (int i = 0; i < NST; i++) begin
            if (pre_v_reg[2] && st_v_reg[i] && st_reg[i].addr == pre_reg[2].addr) begin
                conflict = 1'b1;
            end
        end
        for (int i = 0; i < S_COVP; i++) begin
            if (st_v_reg[i] && st_reg[i].addr == st_reg[S_COVP].addr) begin
                dup_hit = 1'b1;
            end
        end
    end

    // input stages: variance select, threshold and bin reduction
    always_comb begin
        pre_next[0]        = '0;
        pre_next[0].bin    = s_tdata[BIN_W-1:0];
        pre_next[0].cur_re = s_tdata[BIN_W +: C];
        pre_next[0].cur_im = s_tdata[BIN_W+C +: C];
        pre_next[0].sigma  = use_pat_reg ? s_tdata[BIN_W+2*C +: V] : noise_var_reg;
        if (pre_next[0].sigma == '0) begin
            pre_next[0].sigma = V'(VAR_RESET);
        end
    end

    always_comb begin
        logic [RATIO_W+V-1:0] tp;
        logic [MP_W-1:0]      mp;
        tp = (RATIO_W+V)'(ratio_reg) * (RATIO_W+V)'(pre_reg[0].sigma);
        mp = MP_W'(pre_reg[0].bin) * MP_W'(RECIP);
        pre_next[1]     = pre_reg[0];
        pre_next[1].thr = tp[RATIO_FRAC +: THR_W];
        pre_next[1].qm  = (BINS >= 2**BIN_W) ? '0 : mp[MOD_SHIFT +: BIN_W];
    end

    always_comb begin
        logic [31:0] rem;
        rem = 32'(pre_reg[1].bin) - 32'(pre_reg[1].qm) * 32'(BINS);
        pre_next[2]      = pre_reg[1];
        pre_next[2].addr = rem[ADDR_W-1:0];
    end

    // state memory
    skd_ram #(
        .WIDTH ($bits(state_t)),
        .DEPTH (BINS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_issue),
        .raddr (pre_reg[2].addr),
        .rdata (ram_rdata)
    );

    assign state_q = state_t'(ram_rdata);

    // main pipeline
    always_comb begin
        st_next[S_READ] = pre_reg[2];
    end

    for (genvar s = 1; s < NST; s++) begin : g_stage
        always_comb begin
            logic [V+1:0] r2_re, r2_im;
            logic         ge_re, ge_im;
            r2_re      = {st_reg[s-1].r_re, 1'b0};
            r2_im      = {st_reg[s-1].r_im, 1'b0};
            ge_re      = r2_re >= (V+2)'(st_reg[s-1].den_re);
            ge_im      = r2_im >= (V+2)'(st_reg[s-1].den_im);
            st_next[s] = st_reg[s-1];
            if (s == S_SUM) begin
                st_next[s].prev_re = state_q.prev_re;
                st_next[s].prev_im = state_q.prev_im;
                st_next[s].d_re    = (C+1)'(st_reg[s-1].cur_re) - (C+1)'(state_q.prev_re);
                st_next[s].d_im    = (C+1)'(st_reg[s-1].cur_im) - (C+1)'(state_q.prev_im);
                st_next[s].sum_re  = sat_sum(state_q.cov_re, state_q.covp_re);
                st_next[s].sum_im  = sat_sum(state_q.cov_im, state_q.covp_im);
            end else if (s == S_DEN) begin
                st_next[s].den_re = (V+1)'(st_reg[s-1].sum_re) + (V+1)'(st_reg[s-1].sigma);
                st_next[s].den_im = (V+1)'(st_reg[s-1].sum_im) + (V+1)'(st_reg[s-1].sigma);
                st_next[s].r_re   = (V+1)'(st_reg[s-1].sum_re);
                st_next[s].r_im   = (V+1)'(st_reg[s-1].sum_im);
                st_next[s].q_re   = '0;
                st_next[s].q_im   = '0;
                st_next[s].sq_re  = SQ_W'((SQ_W+1)'(st_reg[s-1].d_re)
                                         * (SQ_W+1)'(st_reg[s-1].d_re));
                st_next[s].sq_im  = SQ_W'((SQ_W+1)'(st_reg[s-1].d_im)
                                         * (SQ_W+1)'(st_reg[s-1].d_im));
            end else if (s < S_GAIN) begin
                st_next[s].r_re = (V+1)'(ge_re ? r2_re - (V+2)'(st_reg[s-1].den_re) : r2_re);
                st_next[s].r_im = (V+1)'(ge_im ? r2_im - (V+2)'(st_reg[s-1].den_im) : r2_im);
                st_next[s].q_re = {st_reg[s-1].q_re[GAIN_W-2:0], ge_re};
                st_next[s].q_im = {st_reg[s-1].q_im[GAIN_W-2:0], ge_im};
                if (s == S_DIV0) begin
                    st_next[s].motion =
                        (CMP_W'(st_reg[s-1].sq_re) > CMP_W'(st_reg[s-1].thr)) ||
                        (CMP_W'(st_reg[s-1].sq_im) > CMP_W'(st_reg[s-1].thr));
                end
            end else if (s == S_GAIN) begin
                st_next[s].q_re = st_reg[s-1].q_re + GAIN_W'(st_reg[s-1].r_re >=
                                  st_reg[s-1].den_re - st_reg[s-1].r_re);
                st_next[s].q_im = st_reg[s-1].q_im + GAIN_W'(st_reg[s-1].r_im >=
                                  st_reg[s-1].den_im - st_reg[s-1].r_im);
            end else if (s == S_MUL) begin
                st_next[s].t_re   = mul_round(st_reg[s-1].q_re, st_reg[s-1].sigma);
                st_next[s].t_im   = mul_round(st_reg[s-1].q_im, st_reg[s-1].sigma);
                st_next[s].cov_re = mul_round(GAIN_W'(Q16_ONE) - st_reg[s-1].q_re,
                                              st_reg[s-1].sum_re);
                st_next[s].cov_im = mul_round(GAIN_W'(Q16_ONE) - st_reg[s-1].q_im,
                                              st_reg[s-1].sum_im);
                st_next[s].out_re = blend(st_reg[s-1].prev_re, st_reg[s-1].d_re,
                                          st_reg[s-1].q_re);
                st_next[s].out_im = blend(st_reg[s-1].prev_im, st_reg[s-1].d_im,
                                          st_reg[s-1].q_im);
            end else begin
                st_next[s].covp_re = mul_round(st_reg[s-1].q_re, st_reg[s-1].t_re);
                st_next[s].covp_im = mul_round(st_reg[s-1].q_im, st_reg[s-1].t_im);
            end
        end
    end

    // writeback: motion restarts the bin from the current value
    always_comb begin
        if (st_reg[S_COVP].motion) begin
            state_wb.prev_re = st_reg[S_COVP].cur_re;
            state_wb.prev_im = st_reg[S_COVP].cur_im;
            state_wb.cov_re  = st_reg[S_COVP].sigma;
            state_wb.cov_im  = st_reg[S_COVP].sigma;
            state_wb.covp_re = st_reg[S_COVP].sigma;
            state_wb.covp_im = st_reg[S_COVP].sigma;
        end else begin
            state_wb.prev_re = st_reg[S_COVP].out_re;
            state_wb.prev_im = st_reg[S_COVP].out_im;
            state_wb.cov_re  = st_reg[S_COVP].cov_re;
            state_wb.cov_im  = st_reg[S_COVP].cov_im;
            state_wb.covp_re = st_reg[S_COVP].covp_re;
            state_wb.covp_im = st_reg[S_COVP].covp_im;
        end
        push_item.motion = st_reg[S_COVP].motion;
        push_item.re     = state_wb.prev_re;
        push_item.im     = state_wb.prev_im;
        push_item.bin    = st_reg[S_COVP].bin;
        ram_we    = clr_reg || push;
        ram_waddr = clr_reg ? clr_cnt_reg : st_reg[S_COVP].addr;
        ram_wdata = clr_reg ? '0 : state_wb;
    end

    // output buffer
    always_comb begin
        m_v_next    = m_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (skid_v_reg) begin
            if (pop) begin
                main_next   = skid_reg;
                skid_v_next = 1'b0;
            end
        end else if (push) begin
            if (!m_v_reg || pop) begin
                main_next = push_item;
                m_v_next  = 1'b1;
            end else begin
                skid_next   = push_item;
                skid_v_next = 1'b1;
            end
        end else if (pop) begin
            m_v_next = 1'b0;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = OUT_W'({main_reg.im, main_reg.re, main_reg.bin});
    assign m_tuser  = main_reg.motion;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_var_reg <= V'(VAR_RESET);
            ratio_reg     <= RATIO_W'(RATIO_RESET);
            use_pat_reg   <= 1'b0;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            pre_v_reg     <= '0;
            st_v_reg      <= '0;
            m_v_reg       <= 1'b0;
            skid_v_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_NOISE_VARIANCE: noise_var_reg <= cfg_data;
                    CFG_MOTION_RATIO:   ratio_reg     <= cfg_data[RATIO_W-1:0];
                    CFG_USE_PATTERN:    use_pat_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (clr_reg) begin
                if (clr_cnt_reg == ADDR_W'(BINS - 1)) begin
                    clr_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (pre_move) begin
                pre_v_reg <= {pre_v_reg[1:0], accept};
            end
            if (run) begin
                st_v_reg <= {st_v_reg[NST-2:0], rd_issue};
            end
            m_v_reg    <= m_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pre_move) begin
            for (int i = 0; i < 3; i++) begin
                pre_reg[i] <= pre_next[i];
            end
        end
        if (run) begin
            for (int i = 0; i < NST; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign gain_ok = (st_reg[S_MUL].q_re <= GAIN_W'(Q16_ONE)) &&
                     (st_reg[S_MUL].q_im <= GAIN_W'(Q16_ONE));

    `SKD_ASSERT_IMPLIES(a_no_accept_in_clear, aclk, aresetn, clr_reg, !s_tready, "taken in clear")
    `SKD_ASSERT_IMPLIES(a_one_item_per_bin, aclk, aresetn, st_v_reg[S_COVP], !dup_hit, "bin twice")
    `SKD_ASSERT_IMPLIES(a_skid_behind_main, aclk, aresetn, skid_v_reg, m_v_reg, "skid, no main")
    `SKD_ASSERT_IMPLIES(a_gain_range, aclk, aresetn, st_v_reg[S_MUL], gain_ok, "gain above one")

endmodule
`default_nettype wire

// ===== design/skd_ram.sv =====
`default_nettype none
module skd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== tb/spectral_kalman_denoise_bin_checker.sv =====
`timescale 1ns / 100ps
module spectral_kalman_denoise_bin_checker
    import skd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  cfg_reg_t     cfg_index,
    input  logic [47:0]  cfg_data,
    output int           mismatches,
    output int           outstanding
);
    localparam logic [127:0] VAR_MAX = (128'd1 << 48) - 1;
    localparam longint COEF_LO = -(64'sd1 <<< 23);
    localparam longint COEF_HI = (64'sd1 <<< 23) - 1;

    typedef struct packed {
        logic [11:0] bin;
        logic [23:0] re;
        logic [23:0] im;
        logic        motion;
    } bin_result_t;

    logic [47:0] noise_var;
    logic [15:0] ratio_sq;
    logic        use_pat;
    longint      prev_re [4096];
    longint      prev_im [4096];
    logic [47:0] cov_re [4096];
    logic [47:0] cov_im [4096];
    logic [47:0] covp_re [4096];
    logic [47:0] covp_im [4096];
    bin_result_t filtered_q[$];

    function automatic logic [127:0] sat48(input logic [127:0] v);
        return (v > VAR_MAX) ? VAR_MAX : v;
    endfunction

    function automatic longint filter_part(input longint cur, input longint prev,
                                           input logic [47:0] cov, input logic [47:0] covp,
                                           input logic [127:0] sigma,
                                           output logic [47:0] cov_n,
                                           output logic [47:0] covp_n);
        logic [127:0] sum, den, gain, t;
        longint acc, o;
        sum    = sat48({80'd0, cov} + {80'd0, covp});
        den    = sum + sigma;
        gain   = ((sum << 17) + den) / (den << 1);
        t      = sat48((gain * sigma + 128'd32768) >> 16);
        covp_n = sat48((gain * t + 128'd32768) >> 16);
        cov_n  = sat48(((128'd65536 - gain) * sum + 128'd32768) >> 16);
        acc    = prev * 65536 + longint'(gain[63:0]) * (cur - prev);
        o      = (acc + 32768) >>> 16;
        if (o < COEF_LO) o = COEF_LO;
        if (o > COEF_HI) o = COEF_HI;
        return o;
    endfunction

    task automatic kalman_predict(input logic [111:0] d);
        logic [11:0] b;
        longint cre, cim, dre, dim, ore, oim;
        logic [127:0] sigma, thr;
        logic [47:0] nc, np;
        logic mv;
        bin_result_t r;
        b     = d[11:0];
        cre   = longint'($signed(d[35:12]));
        cim   = longint'($signed(d[59:36]));
        sigma = use_pat ? {80'd0, d[107:60]} : {80'd0, noise_var};
        if (sigma == 0) sigma = 1;
        thr = ({112'd0, ratio_sq} * sigma) >> 8;
        dre = cre - prev_re[b];
        dim = cim - prev_im[b];
        if (dre < 0) dre = -dre;
        if (dim < 0) dim = -dim;
        mv = (128'(dre * dre) > thr) || (128'(dim * dim) > thr);
        if (mv) begin
            ore = cre;
            oim = cim;
            cov_re[b] = sigma[47:0]; covp_re[b] = sigma[47:0];
            cov_im[b] = sigma[47:0]; covp_im[b] = sigma[47:0];
        end else begin
            ore = filter_part(cre, prev_re[b], cov_re[b], covp_re[b], sigma, nc, np);
            cov_re[b] = nc; covp_re[b] = np;
            oim = filter_part(cim, prev_im[b], cov_im[b], covp_im[b], sigma, nc, np);
            cov_im[b] = nc; covp_im[b] = np;
        end
        prev_re[b] = ore;
        prev_im[b] = oim;
        r.bin    = b;
        r.re     = ore[23:0];
        r.im     = oim[23:0];
        r.motion = mv;
        filtered_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        bin_result_t e, a;
        if (!aresetn) begin
            noise_var = 48'(VAR_RESET);
            ratio_sq  = 16'(RATIO_RESET);
            use_pat   = 1'b0;
            for (int i = 0; i < 4096; i++) begin
                prev_re[i] = 0; prev_im[i] = 0;
                cov_re[i] = '0; cov_im[i] = '0;
                covp_re[i] = '0; covp_im[i] = '0;
            end
            filtered_q.delete();
            mismatches  <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NOISE_VARIANCE: noise_var = cfg_data;
                    CFG_MOTION_RATIO:   ratio_sq  = cfg_data[15:0];
                    CFG_USE_PATTERN:    use_pat   = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) kalman_predict(s_tdata);
            if (m_tvalid && m_tready) begin
                a = {m_tdata[11:0], m_tdata[35:12], m_tdata[59:36], m_tuser};
                if (filtered_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected item: bin %0d re %0d im %0d motion %0b",
                                 a.bin, $signed(a.re), $signed(a.im), a.motion);
                    mismatches <= mismatches + 1;
                end else begin
                    e = filtered_q.pop_front();
                    if (e != a) begin
                        if (mismatches < 10)
                            $display("mismatch: exp bin %0d re %0d im %0d mo %0b, got bin %0d re %0d im %0d mo %0b",
                                     e.bin, $signed(e.re), $signed(e.im), e.motion,
                                     a.bin, $signed(a.re), $signed(a.im), a.motion);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        outstanding <= filtered_q.size();
    end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import skd_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    cfg_reg_t     cfg_index;
    logic [47:0]  cfg_data;
    int           mismatches;
    int           outstanding;
    int           burst_left;
    int           idle_cycles;
    int           stall_mode;
    longint       last_re [16];
    longint       last_im [16];

    localparam logic [47:0] VAR_TOP = '1;

    spectral_kalman_denoise_bin u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    spectral_kalman_denoise_bin_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    // receiver stall pattern: one of four modes, re-chosen at random as rx_cnt advances
    int rx_cnt = 0;
    always @(negedge aclk) begin
        rx_cnt <= rx_cnt + 1;
        if (rx_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= (rx_cnt % 7 < 4);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_item(input logic [11:0] bin, input logic [23:0] re,
                             input logic [23:0] im, input logic [47:0] var_in);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left = burst_left - 1;
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, var_in, im, re, bin};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid = 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_phase(input int n);
        int k;
        logic [47:0] v;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 15);
            v = 48'({$urandom, $urandom});
            if ($urandom_range(0, 9) == 0) v = ($urandom_range(0, 1) == 1) ? VAR_TOP : '0;
            if ($urandom_range(0, 4) == 0) begin
                send_item(12'($urandom), 24'($urandom), 24'($urandom), v);
            end else begin
                // small drift on sixteen bins so the filter state evolves
                last_re[k] = last_re[k] + $signed($urandom_range(0, 64)) - 32;
                last_im[k] = last_im[k] + $signed($urandom_range(0, 64)) - 32;
                if ($urandom_range(0, 30) == 0) last_re[k] = $signed(24'($urandom));
                send_item(12'(k * 257), last_re[k][23:0], last_im[k][23:0],
                          {28'd0, 20'($urandom)} | 48'd1);
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_NOISE_VARIANCE;
        cfg_data   = '0;
        m_tready   = 1'b0;
        stall_mode = 0;
        burst_left = 0;
        idle_cycles = 0;
        for (int i = 0; i < 16; i++) begin
            last_re[i] = 0;
            last_im[i] = 0;
        end
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, repeated bins, zero variance
        send_item(12'd0, 24'h000000, 24'h000000, 48'd0);
        send_item(12'd4095, 24'h7FFFFF, 24'h800000, VAR_TOP);
        send_item(12'd4095, 24'h800000, 24'h7FFFFF, 48'd0);
        send_item(12'd4095, 24'h800000, 24'h7FFFFF, 48'd0);
        send_item(12'd1, 24'd1, 24'hFFFFFF, 48'd5);
        drain();
        write_reg(CFG_NOISE_VARIANCE, VAR_TOP);
        write_reg(CFG_MOTION_RATIO, 48'd65535);
        send_item(12'd4095, 24'h7FFFFF, 24'h800000, 48'd0);
        send_item(12'd4095, 24'h800000, 24'h7FFFFF, 48'd0);
        send_item(12'd4095, 24'h000000, 24'h000000, 48'd0);
        send_item(12'd2, 24'd100, 24'hFFFF9C, 48'd0);
        send_item(12'd2, 24'd101, 24'hFFFF9B, 48'd0);
        send_item(12'd2, 24'd99, 24'hFFFF9D, 48'd0);
        drain();
        write_reg(CFG_USE_PATTERN, 48'd1);
        write_reg(CFG_MOTION_RATIO, 48'd0);
        send_item(12'd3, 24'd0, 24'd0, 48'd0);
        send_item(12'd3, 24'd0, 24'd0, 48'd0);
        send_item(12'd3, 24'd1, 24'd0, VAR_TOP);
        send_item(12'd3, 24'h7FFFFF, 24'h800000, VAR_TOP);
        send_item(12'd3, 24'h7FFFFF, 24'h800000, VAR_TOP);
        drain();

        write_reg(CFG_USE_PATTERN, 48'd0);
        write_reg(CFG_NOISE_VARIANCE, 48'd1);
        write_reg(CFG_MOTION_RATIO, 48'd256);
        random_phase(300);
        drain();
        write_reg(CFG_NOISE_VARIANCE, 48'd4096);
        write_reg(CFG_MOTION_RATIO, 48'd4096);
        random_phase(400);
        drain();
        write_reg(CFG_USE_PATTERN, 48'd1);
        write_reg(CFG_MOTION_RATIO, 48'd65535);
        random_phase(400);
        drain();
        write_reg(CFG_USE_PATTERN, 48'd0);
        write_reg(CFG_NOISE_VARIANCE, VAR_TOP);
        write_reg(CFG_MOTION_RATIO, 48'd0);
        random_phase(300);
        drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
